// ===== hw/rtl/bfa_pkg.sv =====
// Shared constants, codes and interface types of the bitmap frame allocator.
package bfa_pkg;

  // Bitmap geometry: 1024 words of 32 frames each.
  localparam int WORDS     = 1024;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = 10;
  localparam int BIT_W     = 5;
  localparam int FRAME_W   = 15;
  localparam int CNT_W     = 16;
  localparam logic [CNT_W-1:0] MAX_FRAMES = 16'h8000;

  // Stream payload widths.
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 48;
  localparam int M_USER_W = 2;

  typedef enum logic [1:0] {
    OP_ALLOC       = 2'd0,
    OP_FREE        = 2'd1,
    OP_REGION_FREE = 2'd2,
    OP_MARK_USED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_RUN = 2'd1,
    STS_ZERO   = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic fill;
    logic scan;
    logic mark_rd;
    logic mark_wr;
    logic zero_rd;
    logic zero_wr;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic zero_cnt;
    logic enough;
    logic rng_empty;
    logic scan_hit;
    logic scan_last;
    logic at_hi;
    logic fill_last;
  } dp_status_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] alloc_frame;
    logic [CNT_W-1:0]   used_frames;
    logic [CNT_W-1:0]   free_frames;
  } result_t;

endpackage

// ===== hw/rtl/bfa_ctrl.sv =====
// Sequencing state machine of the bitmap frame allocator.
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  input  logic                out_free,
  input  bfa_pkg::dp_status_t st,
  output logic                in_ready,
  output bfa_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_DECIDE, S_SCAN, S_MRD, S_MWR, S_ZRD, S_ZWR, S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // Commands follow directly from the state, with load qualified by in_valid and emit by out_free.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_FILL:   cmd.fill    = 1'b1;
      S_IDLE:   cmd.load    = in_valid;
      S_DECIDE: cmd.decide  = 1'b1;
      S_SCAN:   cmd.scan    = 1'b1;
      S_MRD:    cmd.mark_rd = 1'b1;
      S_MWR:    cmd.mark_wr = 1'b1;
      S_ZRD:    cmd.zero_rd = 1'b1;
      S_ZWR:    cmd.zero_wr = 1'b1;
      S_DONE:   cmd.emit    = out_free;
      default:  cmd = '0;
    endcase
  end

  // State register; a configuration write restarts the fill sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else if (cfg_we) begin
      state <= S_FILL;
    end else begin
      unique case (state)
        S_FILL:   if (st.fill_last) state <= S_IDLE;
        S_IDLE:   if (in_valid) state <= S_DECIDE;
        S_DECIDE: begin
          if (st.zero_cnt) begin
            state <= S_DONE;
          end else if (st.op == bfa_pkg::OP_ALLOC) begin
            state <= st.enough ? S_SCAN : S_DONE;
          end else if (st.rng_empty) begin
            state <= (st.op == bfa_pkg::OP_REGION_FREE) ? S_ZRD : S_DONE;
          end else begin
            state <= S_MRD;
          end
        end
        S_SCAN: begin
          if (st.scan_hit) state <= S_MRD;
          else if (st.scan_last) state <= S_DONE;
        end
        S_MRD:    state <= S_MWR;
        S_MWR: begin
          if (st.at_hi) begin
            state <= (st.op == bfa_pkg::OP_REGION_FREE) ? S_ZRD : S_DONE;
          end else begin
            state <= S_MRD;
          end
        end
        S_ZRD:    state <= S_ZWR;
        S_ZWR:    state <= S_DONE;
        S_DONE:   if (out_free) state <= S_IDLE;
        default:  state <= S_FILL;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bfa_datapath.sv =====
// Bitmap memory, run search, range marking and frame counters.
module bfa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bfa_pkg::CNT_W-1:0]           cfg_value,
  input  bfa_pkg::cmd_t                       cmd,
  input  logic [1:0]                          in_op,
  input  logic [bfa_pkg::FRAME_W-1:0]         in_base,
  input  logic [bfa_pkg::CNT_W-1:0]           in_count,
  output bfa_pkg::dp_status_t                 st,
  output bfa_pkg::result_t                    res
);

  localparam int LEVELS = bfa_pkg::BIT_W;

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::WORDS];
  logic [bfa_pkg::WORD_BITS-1:0] rd_data;

  logic [bfa_pkg::CNT_W-1:0]   total;
  logic [bfa_pkg::CNT_W-1:0]   used_cnt;
  bfa_pkg::op_t                op;
  logic [bfa_pkg::FRAME_W-1:0] base;
  logic [bfa_pkg::CNT_W-1:0]   count;
  logic [bfa_pkg::ADDR_W-1:0]  ptr;
  logic [bfa_pkg::ADDR_W-1:0]  proc_w;
  logic                        rd_pend;
  logic [bfa_pkg::CNT_W-1:0]   runin;
  logic [bfa_pkg::FRAME_W-1:0] run_start;
  logic [bfa_pkg::FRAME_W-1:0] lo;
  logic [bfa_pkg::FRAME_W-1:0] hi;
  bfa_pkg::status_t            status_r;
  logic [bfa_pkg::FRAME_W-1:0] alloc_r;

  // Decision terms for the latched item.
  logic [bfa_pkg::CNT_W-1:0]   free_cnt;
  logic [bfa_pkg::CNT_W-1:0]   base16;
  logic [bfa_pkg::CNT_W:0]     end17;
  logic [bfa_pkg::CNT_W-1:0]   endc;
  logic [bfa_pkg::CNT_W-1:0]   rng_n;
  logic [bfa_pkg::CNT_W-1:0]   rng_hi;
  logic [bfa_pkg::CNT_W:0]     sum_n;
  logic [bfa_pkg::CNT_W-1:0]   used_range;
  logic [bfa_pkg::CNT_W:0]     sum_c;
  logic [bfa_pkg::CNT_W-1:0]   used_alloc;
  logic                        mark_used;

  assign free_cnt   = total - used_cnt;
  assign base16     = {1'b0, base};
  assign end17      = {1'b0, base16} + {1'b0, count};
  assign endc       = (end17 > {1'b0, total}) ? total : end17[bfa_pkg::CNT_W-1:0];
  assign rng_n      = endc - base16;
  assign rng_hi     = endc - 16'd1;
  assign sum_n      = {1'b0, used_cnt} + {1'b0, rng_n};
  assign sum_c      = {1'b0, used_cnt} + {1'b0, count};
  assign used_alloc = (sum_c > {1'b0, total}) ? total : sum_c[bfa_pkg::CNT_W-1:0];
  assign mark_used  = (op == bfa_pkg::OP_ALLOC) || (op == bfa_pkg::OP_MARK_USED);

  always_comb begin
    if (op == bfa_pkg::OP_MARK_USED) begin
      used_range = (sum_n > {1'b0, total}) ? total : sum_n[bfa_pkg::CNT_W-1:0];
    end else begin
      used_range = (used_cnt > rng_n) ? used_cnt - rng_n : '0;
    end
  end

  // Run search over one word: last used bit at or below each position.
  logic [bfa_pkg::CNT_W-1:0]   tot_m1;
  logic [bfa_pkg::ADDR_W-1:0]  last_w;
  logic [bfa_pkg::WORD_BITS-1:0] fw;
  logic [bfa_pkg::WORD_BITS-1:0] pv [LEVELS+1];
  logic [bfa_pkg::BIT_W-1:0]   pidx [LEVELS+1][bfa_pkg::WORD_BITS];
  logic [bfa_pkg::CNT_W-1:0]   need;
  logic [bfa_pkg::WORD_BITS-1:0] hit;
  logic [bfa_pkg::BIT_W-1:0]   hit_pos;
  logic                        any_hit;
  logic [bfa_pkg::FRAME_W-1:0] start_eff;
  logic [bfa_pkg::FRAME_W-1:0] found_start;
  logic [bfa_pkg::FRAME_W-1:0] found_end;
  logic [bfa_pkg::FRAME_W-1:0] next_start;
  logic [bfa_pkg::CNT_W-1:0]   found_hi;

  assign tot_m1 = total - 16'd1;
  assign last_w = tot_m1[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
  assign need   = count - runin;
  assign start_eff = (runin == '0) ? {proc_w, {bfa_pkg::BIT_W{1'b0}}} : run_start;

  always_comb begin
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      fw[i] = rd_data[i] ||
              ((proc_w == last_w) && (bfa_pkg::BIT_W'(i) > tot_m1[bfa_pkg::BIT_W-1:0]));
      pv[0][i]   = fw[i];
      pidx[0][i] = bfa_pkg::BIT_W'(i);
    end
    for (int k = 0; k < LEVELS; k++) begin
      for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
        if (!pv[k][i] && (i >= (1 << k))) begin
          pv[k+1][i]   = pv[k][i - (1 << k)];
          pidx[k+1][i] = pidx[k][i - (1 << k)];
        end else begin
          pv[k+1][i]   = pv[k][i];
          pidx[k+1][i] = pidx[k][i];
        end
      end
    end
  end

  // A position hits when the free run ending there reaches the count.
  always_comb begin
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      if (pv[LEVELS][i]) begin
        hit[i] = (count <= 16'd32) &&
                 ({11'd0, bfa_pkg::BIT_W'(bfa_pkg::BIT_W'(i) - pidx[LEVELS][i])} >= count);
      end else begin
        hit[i] = (16'(i + 1) >= need);
      end
    end
    hit_pos = '0;
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) hit_pos = bfa_pkg::BIT_W'(i);
    end
  end

  assign any_hit   = rd_pend && (hit != '0);
  assign found_end = {proc_w, pidx[LEVELS][hit_pos]} + 15'd1;
  assign found_start = pv[LEVELS][hit_pos] ? found_end : start_eff;
  assign found_hi  = {1'b0, found_start} + count - 16'd1;
  assign next_start = {proc_w, pidx[LEVELS][bfa_pkg::WORD_BITS-1]} + 15'd1;

  // Word mask of the range being marked.
  logic [bfa_pkg::WORD_BITS-1:0] mmask;
  logic [bfa_pkg::WORD_BITS-1:0] wdata;
  logic [bfa_pkg::ADDR_W-1:0]    mem_addr;
  logic                          mem_we;
  logic                          mem_re;

  always_comb begin
    mmask = '1;
    if (ptr == lo[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]) begin
      mmask = mmask & ({bfa_pkg::WORD_BITS{1'b1}} << lo[bfa_pkg::BIT_W-1:0]);
    end
    if (ptr == hi[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]) begin
      mmask = mmask & ({bfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi[bfa_pkg::BIT_W-1:0]));
    end
    if (cmd.fill) begin
      wdata = '1;
    end else if (cmd.zero_wr) begin
      wdata = rd_data | 32'd1;
    end else if (mark_used) begin
      wdata = rd_data | mmask;
    end else begin
      wdata = rd_data & ~mmask;
    end
  end

  assign mem_addr = (cmd.zero_rd || cmd.zero_wr) ? '0 : ptr;
  assign mem_we   = cmd.fill || cmd.mark_wr || cmd.zero_wr;
  assign mem_re   = cmd.scan || cmd.mark_rd || cmd.zero_rd;

  // Bitmap memory, one port each way.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wdata;
    if (mem_re) rd_data <= mem[mem_addr];
  end

  // Control registers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      used_cnt <= '0;
      ptr      <= '0;
      rd_pend  <= 1'b0;
    end else if (cfg_we) begin
      total    <= (cfg_value > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : cfg_value;
      used_cnt <= (cfg_value > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : cfg_value;
      ptr      <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (cmd.fill || cmd.mark_wr) ptr <= ptr + 10'd1;
      if (cmd.decide && (count != '0)) begin
        if (op == bfa_pkg::OP_ALLOC) begin
          ptr     <= '0;
          rd_pend <= 1'b0;
        end else if (!st.rng_empty) begin
          used_cnt <= used_range;
          ptr      <= base[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
        end
      end
      if (cmd.scan) begin
        rd_pend <= 1'b1;
        if (any_hit) begin
          used_cnt <= used_alloc;
          ptr      <= found_start[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
        end else begin
          ptr      <= ptr + 10'd1;
        end
      end
    end
  end

  // Item and search registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= bfa_pkg::op_t'(in_op);
      base  <= in_base;
      count <= in_count;
    end
    if (cmd.decide) begin
      alloc_r   <= '0;
      runin     <= '0;
      run_start <= '0;
      lo        <= base;
      hi        <= rng_hi[bfa_pkg::FRAME_W-1:0];
      if (count == '0) begin
        status_r <= bfa_pkg::STS_ZERO;
      end else if ((op == bfa_pkg::OP_ALLOC) && (free_cnt < count)) begin
        status_r <= bfa_pkg::STS_NO_RUN;
      end else begin
        status_r <= bfa_pkg::STS_OK;
      end
    end
    if (cmd.scan) begin
      proc_w <= ptr;
      if (any_hit) begin
        alloc_r <= found_start;
        lo      <= found_start;
        hi      <= found_hi[bfa_pkg::FRAME_W-1:0];
      end else if (rd_pend) begin
        if (proc_w == last_w) status_r <= bfa_pkg::STS_NO_RUN;
        if (pv[LEVELS][bfa_pkg::WORD_BITS-1]) begin
          runin     <= {11'd0, 5'd31 - pidx[LEVELS][bfa_pkg::WORD_BITS-1]};
          run_start <= next_start;
        end else begin
          runin     <= runin + 16'd32;
          run_start <= start_eff;
        end
      end
    end
  end

  // Status to the controller.
  assign st.op        = op;
  assign st.zero_cnt  = (count == '0);
  assign st.enough    = (free_cnt >= count);
  assign st.rng_empty = (base16 >= total);
  assign st.scan_hit  = any_hit;
  assign st.scan_last = rd_pend && (proc_w == last_w);
  assign st.at_hi     = (ptr == hi[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]);
  assign st.fill_last = (ptr == bfa_pkg::ADDR_W'(bfa_pkg::WORDS - 1));

  // Result fields.
  assign res.status      = status_r;
  assign res.alloc_frame = alloc_r;
  assign res.used_frames = used_cnt;
  assign res.free_frames = total - used_cnt;

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Top level of the bitmap frame allocator: controller, datapath and output register.
// Steps: a zero count or an allocate short of frames goes from the decision straight to
// the result; free and mark ops read and write each word touched (then word 0 for region
// free); allocate scans words until a run is found, then marks each word of the run.
// One item at a time. Reset (and each total_frames write) runs a sweep that sets every
// bitmap word to all ones; no item is taken during it. Counters and total reset to zero.
module bitmap_frame_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfa_pkg::CNT_W-1:0]      cfg_data,   // total_frames
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bfa_pkg::S_DATA_W-1:0]   s_tdata,    // base_frame[14:0], frame_count[30:15]
  input  logic [bfa_pkg::S_USER_W-1:0]   s_tuser,    // opcode[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bfa_pkg::M_DATA_W-1:0]   m_tdata,    // alloc_frame, used_frames, free_frames
  output logic [bfa_pkg::M_USER_W-1:0]   m_tuser     // status[1:0]
);

  bfa_pkg::cmd_t       cmd;
  bfa_pkg::dp_status_t st;
  bfa_pkg::result_t    res;
  logic                cfg_we;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .st       (st),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  bfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .in_op     (s_tuser),
    .in_base   (s_tdata[14:0]),
    .in_count  (s_tdata[30:15]),
    .st        (st),
    .res       (res)
  );

  // Output register: holds a finished result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= res.status;
      m_tdata <= {1'b0, res.free_frames, res.used_frames, res.alloc_frame};
    end
  end

`ifndef SYNTHESIS
  // A failed or empty request never reports a frame.
  a_fail_no_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != bfa_pkg::STS_OK)) |-> (m_tdata[14:0] == '0))
    else $error("nonzero alloc_frame on a failed request");

  // In the cycle after a transaction is taken, the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  // Used plus free never exceeds the bitmap capacity.
  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[30:15]} + {1'b0, m_tdata[46:31]} <= 17'd32768))
    else $error("frame counters exceed capacity");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bitmap frame allocator: directed and random operations.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bfa_pkg::CNT_W-1:0]    cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [bfa_pkg::S_DATA_W-1:0] s_tdata = '0;  // base_frame[14:0], frame_count[30:15]
  logic [bfa_pkg::S_USER_W-1:0] s_tuser = '0;  // opcode[1:0]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  // alloc_frame[14:0], used_frames[30:15], free_frames[46:31]
  logic [bfa_pkg::M_DATA_W-1:0] m_tdata;
  logic [bfa_pkg::M_USER_W-1:0] m_tuser;       // status[1:0]

  // Shadow copy of the allocator state.
  bit               frame_map [bfa_pkg::WORDS*bfa_pkg::WORD_BITS];
  int               used_count;
  int               total_reg;
  bfa_pkg::result_t pending_results[$];
  int               alloc_base_q[$];
  int               alloc_len_q[$];
  int               error_count;
  bit               quiet;

  bitmap_frame_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int managed_frames();
    return (total_reg < bfa_pkg::WORDS*bfa_pkg::WORD_BITS) ? total_reg
                                                           : bfa_pkg::WORDS*bfa_pkg::WORD_BITS;
  endfunction

  // Set or clear frames below the total, counting each one with saturation.
  function automatic void mark_frames(int base, int count, bit used);
    int tot;
    tot = managed_frames();
    for (int f = base; f < base + count && f < tot; f++) begin
      frame_map[f] = used;
      if (used) begin
        if (used_count < tot) used_count++;
      end else begin
        if (used_count > 0) used_count--;
      end
    end
  endfunction

  // Apply one operation to the shadow state and return the expected result.
  function automatic bfa_pkg::result_t apply_frame_op(bfa_pkg::op_t op, int base, int count);
    bfa_pkg::result_t r;
    int      tot;
    int      run;
    int      start;
    bit      found;
    tot = managed_frames();
    r.status = bfa_pkg::STS_OK;
    r.alloc_frame = '0;
    run = 0;
    start = 0;
    found = 1'b0;
    if (count == 0) begin
      r.status = bfa_pkg::STS_ZERO;
    end else if (op == bfa_pkg::OP_ALLOC) begin
      if (tot - used_count >= count) begin
        for (int f = 0; f < tot && !found; f++) begin
          if (frame_map[f]) begin
            run = 0;
          end else begin
            if (run == 0) start = f;
            run++;
            if (run == count) found = 1'b1;
          end
        end
      end
      if (found) begin
        for (int f = start; f < start + count; f++) frame_map[f] = 1'b1;
        used_count += count;
        if (used_count > tot) used_count = tot;
        r.alloc_frame = start[bfa_pkg::FRAME_W-1:0];
        alloc_base_q.push_back(start);
        alloc_len_q.push_back(count);
      end else begin
        r.status = bfa_pkg::STS_NO_RUN;
      end
    end else if (op == bfa_pkg::OP_FREE || op == bfa_pkg::OP_REGION_FREE) begin
      mark_frames(base, count, 1'b0);
      if (op == bfa_pkg::OP_REGION_FREE) frame_map[0] = 1'b1;
    end else begin
      mark_frames(base, count, 1'b1);
    end
    if (used_count > tot) used_count = tot;
    r.used_frames = used_count[bfa_pkg::CNT_W-1:0];
    r.free_frames = 16'(tot - used_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Send one operation; the prediction is made when the transaction is accepted.
  task automatic send_op(bfa_pkg::op_t op, int base, int count);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, 16'(count), 15'(base)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_frame_op(op, base, count));
  endtask

  task automatic wait_idle();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the frame total; the block refills the map with used frames.
  task automatic write_total(int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    total_reg = value;
    foreach (frame_map[i]) frame_map[i] = 1'b1;
    used_count = managed_frames();
    alloc_base_q.delete();
    alloc_len_q.delete();
  endtask

  // Receiver: random stall after each accepted result.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= (stall_left == 0);
    end else if (m_tvalid && m_tready) begin
      stall_left = quiet ? 0 : $urandom_range(0, 19);
      m_tready <= (stall_left == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    bfa_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) report_mismatch("status", m_tuser, want.status);
        if (m_tdata[14:0] != want.alloc_frame)
          report_mismatch("alloc_frame", m_tdata[14:0], want.alloc_frame);
        if (m_tdata[30:15] != want.used_frames)
          report_mismatch("used_frames", m_tdata[30:15], want.used_frames);
        if (m_tdata[46:31] != want.free_frames)
          report_mismatch("free_frames", m_tdata[46:31], want.free_frames);
      end
    end
  end

  // Operations with no frames under management, then every op at the field extremes.
  task automatic test_directed();
    send_op(bfa_pkg::OP_ALLOC, 0, 1);
    send_op(bfa_pkg::OP_MARK_USED, 32767, 32768);
    send_op(bfa_pkg::OP_REGION_FREE, 5, 3);
    send_op(bfa_pkg::OP_FREE, 0, 0);
    write_total(100);
    send_op(bfa_pkg::OP_ALLOC, 0, 4);
    send_op(bfa_pkg::OP_REGION_FREE, 1, 99);
    send_op(bfa_pkg::OP_ALLOC, 32767, 5);
    send_op(bfa_pkg::OP_ALLOC, 0, 95);
    send_op(bfa_pkg::OP_ALLOC, 0, 94);
    send_op(bfa_pkg::OP_FREE, 10, 5);
    send_op(bfa_pkg::OP_FREE, 30, 2);
    send_op(bfa_pkg::OP_ALLOC, 0, 6);
    send_op(bfa_pkg::OP_ALLOC, 0, 5);
    send_op(bfa_pkg::OP_MARK_USED, 90, 32768);
    send_op(bfa_pkg::OP_FREE, 0, 32768);
    send_op(bfa_pkg::OP_MARK_USED, 32767, 1);
    send_op(bfa_pkg::OP_ALLOC, 0, 0);
    send_op(bfa_pkg::OP_REGION_FREE, 0, 0);
    send_op(bfa_pkg::OP_MARK_USED, 0, 0);
  endtask

  // Random mix, mostly allocate and free of earlier runs, some noise.
  task automatic test_random(int total, int items);
    int tot;
    int pick;
    int base;
    int count;
    int idx;
    write_total(total);
    tot = managed_frames();
    send_op(bfa_pkg::OP_REGION_FREE, 0, tot);
    for (int i = 0; i < items; i++) begin
      if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32768) : $urandom_range(1, 40);
      base  = ($urandom_range(0, 5) == 0 || tot == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, tot - 1);
      if (pick < 40) begin
        send_op(bfa_pkg::OP_ALLOC, $urandom_range(0, 32767), count);
      end else if (pick < 65 && alloc_base_q.size() != 0) begin
        idx = $urandom_range(0, alloc_base_q.size() - 1);
        base = alloc_base_q[idx];
        count = alloc_len_q[idx];
        alloc_base_q.delete(idx);
        alloc_len_q.delete(idx);
        send_op(bfa_pkg::OP_FREE, base, count);
      end else if (pick < 75) begin
        send_op(bfa_pkg::OP_FREE, base, count);
      end else if (pick < 85) begin
        send_op(bfa_pkg::OP_REGION_FREE, base, count);
      end else if (pick < 95) begin
        send_op(bfa_pkg::OP_MARK_USED, base, count);
      end else begin
        send_op(bfa_pkg::op_t'($urandom_range(0, 3)), base, 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    total_reg = 0;
    used_count = 0;
    foreach (frame_map[i]) frame_map[i] = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 60);
    test_random(37, 40);
    test_random(1000, 60);
    test_random(32768, 40);
    test_random(65535, 30);
    test_random(0, 10);
    test_random(64, 30);
    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bfa_datapath.sv
hw/rtl/bitmap_frame_allocator.sv
test/tb.sv
